// ===== rtl/a85_pkg.sv =====
// Shared types and constants for the ASCII85 stream encoder.
package a85_pkg;

   localparam int unsigned DigitCount = 5;
   localparam int unsigned DigitWidth = 7;
   localparam int unsigned CountWidth = $clog2(DigitCount + 1);

   localparam logic [DigitWidth-1:0] DigitBase   = 7'd85;
   localparam logic [DigitWidth-1:0] DigitOffset = 7'h21;
   localparam logic [DigitWidth-1:0] ZeroChar    = 7'h7a;

   // floor(x / 85) == (x * RecipMult) >> RecipShift for every 32-bit x.
   localparam logic [31:0] RecipMult  = 32'd3233857729;
   localparam int unsigned RecipShift = 38;
   localparam int unsigned QuotWidth  = 64 - RecipShift;

   localparam logic [CountWidth-1:0] LastDigit = CountWidth'(DigitCount - 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } a85_req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       run_last;
      logic       stream_end;
   } a85_rsp_type;

   // One group waiting for conversion.
   typedef struct packed {
      logic [31:0]           word;
      logic [CountWidth-1:0] nchars;
      logic                  zero;
      logic                  fin;
   } a85_job_type;

   // One converted group, digits without offset, most significant at index 0.
   typedef struct packed {
      logic [DigitCount-1:0][DigitWidth-1:0] digits;
      logic [CountWidth-1:0]                 nchars;
      logic                                  zero;
      logic                                  fin;
   } a85_grp_type;

endpackage

// ===== rtl/a85_front.sv =====
// Front end: packs input bytes into groups and posts finished groups.
module a85_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  a85_pkg::a85_req_type req_data,
   output logic                 job_push,
   output a85_pkg::a85_job_type job_data,
   input  logic                 job_full
);

   logic [23:0] group_ff, group_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        closes;
   logic [31:0] packed_word;

   assign req_stall = job_full;
   assign accept    = req_valid & ~job_full;
   assign closes    = (count_ff == 2'd3) | req_data.final_byte;
   assign job_push  = accept & closes;

   always_comb begin
      packed_word = {group_ff, req_data.data_byte};
      case (count_ff)
         2'd0:    job_data.word = {packed_word[7:0], 24'd0};
         2'd1:    job_data.word = {packed_word[15:0], 16'd0};
         2'd2:    job_data.word = {packed_word[23:0], 8'd0};
         default: job_data.word = packed_word;
      endcase
      job_data.nchars = a85_pkg::CountWidth'(count_ff) + a85_pkg::CountWidth'(2);
      job_data.zero   = (count_ff == 2'd3) & (packed_word == 32'd0);
      job_data.fin    = req_data.final_byte;
   end

   always_comb begin
      group_in = group_ff;
      count_in = count_ff;
      if (accept) begin
         if (closes) begin
            group_in = 24'd0;
            count_in = 2'd0;
         end else begin
            group_in = {group_ff[15:0], req_data.data_byte};
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= 24'd0;
         count_ff <= 2'd0;
      end else begin
         group_ff <= group_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/a85_queue.sv =====
// Two-entry queue of groups between the front end and the converter.
module a85_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  a85_pkg::a85_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output a85_pkg::a85_job_type pop_data
);

   a85_pkg::a85_job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] used_ff, used_in;

   assign full      = (used_ff == 2'd2);
   assign not_empty = (used_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      used_in   = used_ff;
      if (push & ~pop) begin
         used_in = used_ff + 2'd1;
      end else if (pop & ~push) begin
         used_in = used_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule

// ===== rtl/a85_conv.sv =====
// Converter: splits a 32-bit group into base-85 digits, one digit a cycle.
module a85_conv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_ready,
   input  a85_pkg::a85_job_type job_data,
   output logic                 job_pop,
   output logic                 grp_valid,
   output a85_pkg::a85_grp_type grp_data,
   input  logic                 grp_take
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [a85_pkg::CountWidth-1:0]      cnt_ff, cnt_in;
   logic [31:0]                         rem_ff;
   logic [63:0]                         prod_ff;
   a85_pkg::a85_grp_type                grp_ff;
   logic [a85_pkg::QuotWidth-1:0]       quot;
   logic [31:0]                         quot_times_base;
   logic [31:0]                         diff;
   logic [a85_pkg::DigitWidth-1:0]      digit;
   logic [31:0]                         mul_in;
   logic [63:0]                         prod_in;
   logic [a85_pkg::CountWidth-1:0]      wr_idx;
   logic                                can_load;

   assign grp_valid = done_ff;
   assign grp_data  = grp_ff;

   // Quotient by 85 from the registered reciprocal product; remainder is the digit.
   assign quot            = prod_ff[63:a85_pkg::RecipShift];
   assign quot_times_base = 32'(quot) * 32'(a85_pkg::DigitBase);
   assign diff            = rem_ff - quot_times_base;
   assign digit           = diff[a85_pkg::DigitWidth-1:0];
   assign wr_idx          = a85_pkg::LastDigit - cnt_ff;

   assign can_load = ~busy_ff & (~done_ff | grp_take);
   assign job_pop  = can_load & job_ready;

   // The single multiplier serves both the first step and every later one.
   assign mul_in  = busy_ff ? 32'(quot) : job_data.word;
   assign prod_in = 64'(mul_in) * 64'(a85_pkg::RecipMult);

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      if (done_ff & grp_take) begin
         done_in = 1'b0;
      end
      if (job_pop) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + a85_pkg::CountWidth'(1);
         if (cnt_ff == a85_pkg::LastDigit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rem_ff         <= job_data.word;
         prod_ff        <= prod_in;
         grp_ff.nchars  <= job_data.nchars;
         grp_ff.zero    <= job_data.zero;
         grp_ff.fin     <= job_data.fin;
      end else if (busy_ff) begin
         rem_ff                 <= 32'(quot);
         prod_ff                <= prod_in;
         grp_ff.digits[wr_idx]  <= digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/a85_emit.sv =====
// Output stage: sends the characters of one converted group, one a cycle while rsp_stall is low.
module a85_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 grp_valid,
   input  a85_pkg::a85_grp_type grp_data,
   output logic                 grp_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output a85_pkg::a85_rsp_type rsp_data
);

   logic                           valid_ff, valid_in;
   logic [a85_pkg::CountWidth-1:0] idx_ff, idx_in;
   a85_pkg::a85_grp_type           grp_ff;
   logic [a85_pkg::CountWidth-1:0] last_idx;
   logic                           at_last;
   logic                           sent;

   assign last_idx = grp_ff.zero ? '0 : (grp_ff.nchars - a85_pkg::CountWidth'(1));
   assign at_last  = (idx_ff == last_idx);
   assign sent     = valid_ff & ~rsp_stall;
   assign grp_take = grp_valid & (~valid_ff | (sent & at_last));

   assign rsp_valid           = valid_ff;
   assign rsp_data.out_char   = grp_ff.zero ? a85_pkg::ZeroChar
                                            : grp_ff.digits[idx_ff] + a85_pkg::DigitOffset;
   assign rsp_data.run_last   = at_last;
   assign rsp_data.stream_end = at_last & grp_ff.fin;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (grp_take) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (sent) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + a85_pkg::CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_take) begin
         grp_ff <= grp_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/ascii85_stream_encoder_unit.sv =====
// ASCII85 stream encoder, top level: front end, group queue, converter, output stage.
// This block encodes a byte stream in ASCII85. Each accepted word on the req_ channel
// carries one byte and a flag that marks the last byte of the stream. Bytes are packed
// most significant first into 32-bit groups. A complete group of four zero bytes produces
// the single character 'z'; any other complete group produces five characters, '!' plus
// each base-85 digit, most significant digit first. When the flagged byte closes a partial
// group of n bytes, the group is padded with zero bytes and only its first n+1 characters
// are sent, never 'z'. No terminator is appended. Each rsp_ word carries one character,
// run_last on the last character caused by one input byte, and stream_end on the last
// character of the whole stream. The front end takes one byte a cycle while the two-entry
// group queue has room. The converter divides by 85 with a reciprocal multiply, one digit a
// cycle, and starts a new group only once it has produced all five digits of the last one.
// A group closed early by the final flag still goes through all five digit steps.
// Both sides may stall independently; the queue and the output register absorb the slack.
module ascii85_stream_encoder_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  a85_pkg::a85_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output a85_pkg::a85_rsp_type rsp_data
);

   logic                 job_push;
   a85_pkg::a85_job_type job_in;
   logic                 job_full;
   logic                 job_pop;
   logic                 job_ready;
   a85_pkg::a85_job_type job_out;
   logic                 grp_valid;
   a85_pkg::a85_grp_type grp_data;
   logic                 grp_take;

   // The front end collects bytes and posts a group when it is complete or the stream ends.
   a85_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_push  (job_push),
      .job_data  (job_in),
      .job_full  (job_full)
   );

   // The queue lets the front end keep taking bytes while the converter is busy.
   a85_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .not_empty (job_ready),
      .pop_data  (job_out)
   );

   // The converter produces all five digits of a group before handing it on.
   a85_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .job_ready (job_ready),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .grp_valid (grp_valid),
      .grp_data  (grp_data),
      .grp_take  (grp_take)
   );

   // The output stage sends characters while the converter works on the next group.
   a85_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp_data  (grp_data),
      .grp_take  (grp_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/a85_chk.sv =====
// Port checker for the ASCII85 stream encoder, bound to the top level.
module a85_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input a85_pkg::a85_rsp_type rsp_data
);

   // A stalled result word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result word was withdrawn");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered after reset");

   // The end of the stream is always the last character of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.stream_end || rsp_data.run_last))
      else $error("stream end without run end");

   // Only digit characters or the zero group character ever leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.out_char >= 7'h21 && rsp_data.out_char <= 7'h75)
                     || rsp_data.out_char == 7'h7a))
      else $error("character outside the ASCII85 alphabet");

   // A 'z' stands alone for its group, so it always ends a run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_char == 7'h7a |-> rsp_data.run_last)
      else $error("zero group character not at end of run");

endmodule

bind ascii85_stream_encoder_unit a85_chk u_chk (.*);

// ===== sim/ascii85_stream_encoder_unit_tb.sv =====
// Self-checking testbench for the ASCII85 stream encoder unit.
module ascii85_stream_encoder_unit_tb;

   // Run shape. The tail of the stimulus runs with no idling on either side.
   localparam int unsigned TotalWords = 310;
   localparam int unsigned QuietTail  = 40;
   localparam int unsigned HoldAfter  = 120;
   localparam int unsigned HoldCycles = 150;
   localparam int unsigned DrainAt    = 230;
   localparam int unsigned TailCycles = 30;
   localparam int unsigned CycleLimit = 200000;

   // One queued input word together with the idle gap that precedes it. When
   // drain is set, the word is held back until every expected character has come.
   typedef struct packed {
      a85_pkg::a85_req_type word;
      logic [3:0]           gap;
      logic                 drain;
   } byte_slot_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   a85_pkg::a85_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   a85_pkg::a85_rsp_type rsp_data;

   byte_slot_type        pending_words[$];
   a85_pkg::a85_rsp_type expected_chars[$];

   // Shadow copy of the group being collected: bytes right-aligned, big-endian.
   logic [23:0] held_bytes = '0;
   logic [1:0]  held_count = '0;

   int unsigned          mismatch_count = 0;
   int unsigned          accepted_words = 0;
   int unsigned          cycle_count = 0;
   int unsigned          gap_left = 0;
   int unsigned          hold_left = 0;
   int unsigned          stall_left = 0;
   int unsigned          free_left = 0;
   logic                 hold_done = 1'b0;
   byte_slot_type        slot;
   a85_pkg::a85_rsp_type want;

   ascii85_stream_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predict the characters caused by one accepted byte and queue them. A byte that
   // leaves the group open only updates the shadow state. A closing byte builds the
   // 32-bit group, padding missing low bytes with zero, and emits either 'z' for a
   // full zero group or the leading held+2 base-85 digits, offset into printable range.
   task automatic encode_byte(input a85_pkg::a85_req_type w);
      logic [31:0]          grp;
      logic [6:0]           digit [5];
      int                   nchars;
      a85_pkg::a85_rsp_type ch;
      if (held_count < 2'd3 && !w.final_byte) begin
         held_bytes = {held_bytes[15:0], w.data_byte};
         held_count = held_count + 2'd1;
         return;
      end
      grp = {held_bytes, w.data_byte};
      grp = grp << (8 * (3 - int'(held_count)));
      nchars = int'(held_count) + 2;
      if (held_count == 2'd3 && grp == 32'd0) begin
         ch.out_char   = a85_pkg::ZeroChar;
         ch.run_last   = 1'b1;
         ch.stream_end = w.final_byte;
         expected_chars.push_back(ch);
      end else begin
         for (int i = 4; i >= 0; i--) begin
            digit[i] = 7'(grp % 32'd85);
            grp = grp / 32'd85;
         end
         for (int i = 0; i < nchars; i++) begin
            ch.out_char   = digit[i] + a85_pkg::DigitOffset;
            ch.run_last   = (i == nchars - 1);
            ch.stream_end = (i == nchars - 1) && w.final_byte;
            expected_chars.push_back(ch);
         end
      end
      held_bytes = '0;
      held_count = '0;
   endtask

   task automatic add_word(input logic [7:0] value, input logic last_flag,
                           input int unsigned gap, input logic drain);
      byte_slot_type s;
      s.word.data_byte  = value;
      s.word.final_byte = last_flag;
      s.gap             = 4'(gap);
      s.drain           = drain;
      pending_words.push_back(s);
   endtask

   // Sender. The expectation is formed on the edge at which the word is taken.
   // A stalled word stays on the bus unchanged; otherwise the next queued word is
   // offered after its gap, and a drain word waits for the result side to empty.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data);
            accepted_words <= accepted_words + 1;
         end
         if (req_valid && req_stall) begin
            // The word is held until the block takes it.
         end else if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0 ||
                      (pending_words[0].drain && expected_chars.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (pending_words[0].gap != 0) begin
            slot = pending_words.pop_front();
            gap_left <= slot.gap - 1;
            slot.gap = '0;
            pending_words.push_front(slot);
            req_valid <= 1'b0;
         end else begin
            slot = pending_words.pop_front();
            req_data  <= slot.word;
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver stall pattern. Once, after enough words have gone in, the receiver
   // holds off for a long stretch so the group queue fills and the block stalls its
   // input. Otherwise random stall bursts alternate with free-running
   // stretches, and the tail of the run is not stalled at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         free_left  <= 0;
         hold_left  <= 0;
      end else if (!hold_done && accepted_words >= HoldAfter) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (pending_words.size() < QuietTail) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (free_left != 0) begin
         free_left <= free_left - 1;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_stall  <= 1'b1;
      end else begin
         free_left <= $urandom_range(0, 24);
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: every accepted character is matched field by field against the
   // oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.out_char !== want.out_char) begin
               $display("%0t: out_char expected %h actual %h",
                        $time, want.out_char, rsp_data.out_char);
               mismatch_count++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $display("%0t: run_last expected %b actual %b",
                        $time, want.run_last, rsp_data.run_last);
               mismatch_count++;
            end
            if (rsp_data.stream_end !== want.stream_end) begin
               $display("%0t: stream_end expected %b actual %b",
                        $time, want.stream_end, rsp_data.stream_end);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int unsigned len;
      int unsigned kind;
      int unsigned gap;
      logic [7:0]  value;
      logic        last_flag;
      logic        noisy;
      logic        calm;
      logic        drain_placed;

      // Directed part. A full zero group gives 'z'; all ones gives the largest digits.
      for (int i = 0; i < 4; i++) add_word(8'h00, 1'b0, 0, 1'b0);
      for (int i = 0; i < 4; i++) add_word(8'hff, 1'b0, 0, 1'b0);
      // A zero group closed by the final byte: 'z' that also ends the stream.
      for (int i = 0; i < 4; i++) add_word(8'h00, i == 3, 0, 1'b0);
      // A lone zero byte as the whole stream is padded and must not become 'z'.
      add_word(8'h00, 1'b1, 0, 1'b0);
      // Partial groups of two and three bytes closed by the final flag.
      add_word(8'h80, 1'b0, 2, 1'b0);
      add_word(8'h01, 1'b1, 0, 1'b0);
      add_word(8'hff, 1'b0, 0, 1'b0);
      add_word(8'hff, 1'b0, 1, 1'b0);
      add_word(8'hff, 1'b1, 0, 1'b0);
      // A lone all-ones byte as a stream.
      add_word(8'hff, 1'b1, 0, 1'b0);
      // A full nonzero group whose fourth byte is final.
      add_word(8'h55, 1'b0, 0, 1'b0);
      add_word(8'haa, 1'b0, 0, 1'b0);
      add_word(8'h0f, 1'b0, 3, 1'b0);
      add_word(8'hf0, 1'b1, 0, 1'b0);
      // Three zero bytes, the third one final: padded partial group, still no 'z'.
      add_word(8'h00, 1'b0, 0, 1'b0);
      add_word(8'h00, 1'b0, 0, 1'b0);
      add_word(8'h00, 1'b1, 0, 1'b0);

      // Random part: streams of random length, mostly well formed, with zero-heavy
      // and all-ones content mixed in. Noisy streams raise the final flag early.
      drain_placed = 1'b0;
      while (pending_words.size() < TotalWords) begin
         len   = $urandom_range(1, 12);
         kind  = $urandom_range(0, 5);
         noisy = ($urandom_range(0, 7) == 0);
         calm  = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < len; k++) begin
            case (kind)
               0: value = 8'h00;
               1: value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
               2: value = 8'hff;
               default: value = 8'($urandom_range(0, 255));
            endcase
            last_flag = (k == len - 1) || (noisy && $urandom_range(0, 3) == 0);
            if (calm || pending_words.size() >= TotalWords - QuietTail) begin
               gap = 0;
            end else begin
               gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
            end
            if (!drain_placed && k == 0 && pending_words.size() >= DrainAt) begin
               add_word(value, last_flag, gap, 1'b1);
               drain_placed = 1'b1;
            end else begin
               add_word(value, last_flag, gap, 1'b0);
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (TailCycles) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
